>>> rtl/mxt_pkg.sv
// ----------------------------------------------------------------------------
// mxt_pkg
// Shared sizes, types and helpers for the maximum subarray xor trie block.
// ----------------------------------------------------------------------------
package mxt_pkg;

    // key and node memory sizing
    localparam int KEY_BITS      = 32;
    localparam int NODE_CAPACITY = 32768;
    localparam int NODE_W        = $clog2(NODE_CAPACITY);
    localparam int USED_W        = NODE_W + 1;
    localparam int ENTRY_W       = 2 * NODE_W;
    localparam int LVL_W         = $clog2(KEY_BITS);

    localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [NODE_W-1:0]   t_node;
    typedef logic [USED_W-1:0]   t_used;
    typedef logic [ENTRY_W-1:0]  t_entry;
    typedef logic [LVL_W-1:0]    t_lvl;

    localparam t_lvl TOP_LVL = LVL_W'(KEY_BITS - 1);

    // walk request from the stream side
    typedef struct packed {
        logic start;
        logic clear;
        t_key key;
    } t_cmd;

    // walk response back to the stream side
    typedef struct packed {
        logic done;
        t_key xor_val;
        logic overflow;
    } t_rsp;

    // sign-extend the 32-bit prefix and keep the low key bits
    function automatic t_key make_key(input logic [31:0] p);
        logic [63:0] w;
        w = {{32{p[31]}}, p};
        return w[KEY_BITS-1:0];
    endfunction

    // sign-extend a key-wide xor to 32 bits
    function automatic logic [31:0] to_out32(input t_key r);
        logic [63:0] w;
        w = 64'($signed(r));
        return w[31:0];
    endfunction

    // child index of an entry, stored as {child1, child0}
    function automatic t_node child_of(input t_entry e, input logic b);
        return b ? e[ENTRY_W-1:NODE_W] : e[NODE_W-1:0];
    endfunction

    // entry with one child replaced
    function automatic t_entry with_child(input t_entry e, input logic b, input t_node c);
        t_entry r;
        r = e;
        if (b) begin
            r[ENTRY_W-1:NODE_W] = c;
        end else begin
            r[NODE_W-1:0] = c;
        end
        return r;
    endfunction

endpackage

>>> rtl/mxt_ram.sv
// ----------------------------------------------------------------------------
// mxt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mxt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mxt_walker.sv
// ----------------------------------------------------------------------------
// mxt_walker
// Trie walk engine: clears the trie, runs the query walk and the insert walk
// over the node memory, one node access per cycle.
// ----------------------------------------------------------------------------
module mxt_walker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mxt_pkg::t_cmd  i_cmd,
    output mxt_pkg::t_rsp  o_rsp,
    output logic           o_ram_we,
    output mxt_pkg::t_node o_ram_waddr,
    output mxt_pkg::t_entry o_ram_wdata,
    output mxt_pkg::t_node o_ram_raddr,
    input  mxt_pkg::t_entry i_ram_rdata
);
    import mxt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_INS_RD,
        S_INS_CHK,
        S_INS_NEW,
        S_INS_LEAF,
        S_Q_RD,
        S_Q_CHK
    } t_state;

    t_state r_state, n_state;
    t_key   r_key, n_key;
    logic   r_zero, n_zero;
    logic   r_final, n_final;
    t_node  r_cur, n_cur;
    t_lvl   r_lvl, n_lvl;
    t_used  r_used, n_used;
    logic   r_ovf, n_ovf;
    t_key   r_qres, n_qres;
    logic   r_done, n_done;

    t_key  ins_key;
    logic  ins_bit;
    t_node ins_child;
    logic  full;
    t_node new_idx;
    logic  q_bit;
    logic  q_pref;
    logic  q_want;
    t_node q_child;
    logic  ins_end;
    logic  q_end;

    // per-level decode of the node just read
    always_comb begin
        ins_key   = r_zero ? '0 : r_key;
        ins_bit   = ins_key[r_lvl];
        ins_child = child_of(i_ram_rdata, ins_bit);
        full      = (r_used == USED_W'(NODE_CAPACITY));
        new_idx   = r_used[NODE_W-1:0];
        q_bit     = r_key[r_lvl];
        // sign bit keeps the same bit, lower bits look for the opposite one
        q_pref    = (r_lvl == TOP_LVL) ? q_bit : ~q_bit;
        q_want    = (child_of(i_ram_rdata, q_pref) != '0) ? q_pref : ~q_pref;
        q_child   = child_of(i_ram_rdata, q_want);
    end

    // walk sequencer
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_zero      = r_zero;
        n_final     = r_final;
        n_cur       = r_cur;
        n_lvl       = r_lvl;
        n_used      = r_used;
        n_ovf       = r_ovf;
        n_qres      = r_qres;
        n_done      = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_cur;
        o_ram_wdata = '0;
        o_ram_raddr = r_cur;
        ins_end     = 1'b0;
        q_end       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_key = i_cmd.key;
                    n_cur = '0;
                    n_lvl = TOP_LVL;
                    if (i_cmd.clear) begin
                        n_state = S_CLR;
                    end else begin
                        n_qres  = '0;
                        n_state = S_Q_RD;
                    end
                end
            end
            // root back to no children, then insert the zero prefix
            S_CLR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = '0;
                o_ram_wdata = '0;
                n_used      = USED_W'(1);
                n_ovf       = 1'b0;
                n_zero      = 1'b1;
                n_final     = 1'b0;
                n_cur       = '0;
                n_lvl       = TOP_LVL;
                n_state     = S_INS_RD;
            end
            S_INS_RD: begin
                n_state = S_INS_CHK;
            end
            // follow the existing path, or allocate where it ends
            S_INS_CHK: begin
                if (ins_child != '0) begin
                    if (r_lvl == '0) begin
                        ins_end = 1'b1;
                    end else begin
                        o_ram_raddr = ins_child;
                        n_cur       = ins_child;
                        n_lvl       = r_lvl - 1'b1;
                    end
                end else if (full) begin
                    n_ovf   = 1'b1;
                    ins_end = 1'b1;
                end else begin
                    o_ram_we    = 1'b1;
                    o_ram_wdata = with_child(i_ram_rdata, ins_bit, new_idx);
                    n_cur       = new_idx;
                    n_used      = r_used + 1'b1;
                    if (r_lvl == '0) begin
                        n_state = S_INS_LEAF;
                    end else begin
                        n_lvl   = r_lvl - 1'b1;
                        n_state = S_INS_NEW;
                    end
                end
            end
            // fresh chain: each new node points at the next one
            S_INS_NEW: begin
                o_ram_we = 1'b1;
                if (full) begin
                    o_ram_wdata = '0;
                    n_ovf       = 1'b1;
                    ins_end     = 1'b1;
                end else begin
                    o_ram_wdata = with_child('0, ins_bit, new_idx);
                    n_cur       = new_idx;
                    n_used      = r_used + 1'b1;
                    if (r_lvl == '0) begin
                        n_state = S_INS_LEAF;
                    end else begin
                        n_lvl = r_lvl - 1'b1;
                    end
                end
            end
            S_INS_LEAF: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = '0;
                ins_end     = 1'b1;
            end
            S_Q_RD: begin
                n_state = S_Q_CHK;
            end
            // query step, a node with no child ends the walk early
            S_Q_CHK: begin
                if (q_child == '0) begin
                    q_end = 1'b1;
                end else begin
                    n_qres[r_lvl] = q_bit ^ q_want;
                    if (r_lvl == '0) begin
                        q_end = 1'b1;
                    end else begin
                        o_ram_raddr = q_child;
                        n_cur       = q_child;
                        n_lvl       = r_lvl - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // query done: insert the new prefix as the last walk
        if (q_end) begin
            n_zero  = 1'b0;
            n_final = 1'b1;
            n_cur   = '0;
            n_lvl   = TOP_LVL;
            n_state = S_INS_RD;
        end

        // insert done: either the transaction ends or the query follows
        if (ins_end) begin
            if (r_final) begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end else begin
                n_qres  = '0;
                n_cur   = '0;
                n_lvl   = TOP_LVL;
                n_state = S_Q_RD;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= USED_W'(1);
            r_ovf   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ovf   <= n_ovf;
            r_done  <= n_done;
        end
        r_key   <= n_key;
        r_zero  <= n_zero;
        r_final <= n_final;
        r_cur   <= n_cur;
        r_lvl   <= n_lvl;
        r_qres  <= n_qres;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.xor_val  = r_qres;
    assign o_rsp.overflow = r_ovf;

endmodule

>>> rtl/max_xor_subarray_trie.sv
// sequence: each transaction runs a query walk, then an insert walk of the new prefix;
//   when a new array starts, the root is cleared and the zero prefix inserted first
// throughput: one transaction at a time, bound by one node memory access per cycle
// reset: the trie counts as empty, so the first transaction always starts an array;
//   no clearing pass, nodes are written as they are allocated
// ----------------------------------------------------------------------------
// max_xor_subarray_trie
// Stream of signed values in, largest subarray xor ending at each value and the
// running maximum out, using a binary trie of prefix xors in node memory.
// ----------------------------------------------------------------------------
module max_xor_subarray_trie (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_start_array,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_best_ending_here,
    output logic signed [31:0] o_running_maximum,
    output logic               o_capacity_exceeded
);
    import mxt_pkg::*;

    logic        r_busy;
    logic        r_wait;
    logic        r_live;
    logic [31:0] r_prefix;
    logic [31:0] r_best;
    logic        r_out_valid;
    logic [31:0] r_out_here;
    logic [31:0] r_out_best;
    logic        r_out_ovf;

    logic        accept;
    logic        clear;
    logic [31:0] n_prefix;
    logic [31:0] here;
    logic [31:0] n_best;
    logic        load;
    t_cmd        cmd;
    t_rsp        rsp;
    logic        ram_we;
    t_node       ram_waddr;
    t_entry      ram_wdata;
    t_node       ram_raddr;
    t_entry      ram_rdata;

    // input transaction and prefix fold
    always_comb begin
        accept   = i_in_valid && !r_busy;
        clear    = i_start_array || !r_live;
        n_prefix = (clear ? 32'h0 : r_prefix) ^ i_value;
        cmd.start = accept;
        cmd.clear = clear;
        cmd.key   = make_key(n_prefix);
    end

    // result and running maximum
    always_comb begin
        here   = to_out32(rsp.xor_val);
        n_best = ($signed(here) > $signed(r_best)) ? here : r_best;
        load   = r_wait && (!r_out_valid || !i_out_stall);
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_wait      <= 1'b0;
            r_live      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_live <= 1'b1;
            end else if (load) begin
                r_busy <= 1'b0;
            end
            if (rsp.done) begin
                r_wait <= 1'b1;
            end else if (load) begin
                r_wait <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_prefix <= n_prefix;
            if (clear) begin
                r_best <= MOST_NEGATIVE;
            end
        end
        if (load) begin
            r_best     <= n_best;
            r_out_here <= here;
            r_out_best <= n_best;
            r_out_ovf  <= rsp.overflow;
        end
    end

    mxt_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_rsp       (rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    mxt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_CAPACITY)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall          = r_busy;
    assign o_out_valid         = r_out_valid;
    assign o_best_ending_here  = r_out_here;
    assign o_running_maximum   = r_out_best;
    assign o_capacity_exceeded = r_out_ovf;

endmodule
